### rtl/core/ncbm_pkg.sv
// ncbm_pkg: shared types, constants and arithmetic helpers for the cubic basemul block
// used by ncbm_core and ntt_cubic_basemul_montgomery_top; no dependencies
`default_nettype none

package ncbm_pkg;

    // modulus and montgomery constants, all fit in 16 signed bits
    localparam logic signed [15:0] MOD_Q        = 16'sd3457;
    localparam logic signed [15:0] MOD_NEG_QINV = -16'sd12929;
    localparam logic signed [15:0] MONT_R       = -16'sd147;
    localparam logic signed [15:0] MONT_RSQ     = 16'sd867;

    // number of register stages from input word to output word
    localparam int NCBM_DEPTH = 10;

    // input word
    typedef struct packed {
        logic              cmd;
        logic signed [15:0] a_0;
        logic signed [15:0] a_1;
        logic signed [15:0] a_2;
        logic signed [15:0] b_0;
        logic signed [15:0] b_1;
        logic signed [15:0] b_2;
        logic signed [15:0] zeta;
        logic signed [15:0] c_0;
        logic signed [15:0] c_1;
        logic signed [15:0] c_2;
    } ncbm_in_t;

    // output word
    typedef struct packed {
        logic signed [15:0] out_0;
        logic signed [15:0] out_1;
        logic signed [15:0] out_2;
    } ncbm_out_t;

    // full 16x16 signed product
    function automatic logic signed [31:0] mul16(input logic signed [15:0] x,
                                                 input logic signed [15:0] y);
        logic signed [31:0] r;
        r = x * y;
        return r;
    endfunction

    // first half of montgomery reduction: u = low16(x) * -qinv mod 2^16
    function automatic logic signed [15:0] mont_u(input logic signed [31:0] x);
        logic [15:0] r;
        r = x[15:0] * $unsigned(MOD_NEG_QINV);
        return $signed(r);
    endfunction

    // second half: high word of x + u*q, wrapping at 32 bits
    function automatic logic signed [15:0] mont_hi(input logic signed [31:0] x,
                                                   input logic signed [15:0] u);
        logic signed [31:0] s;
        s = x + u * MOD_Q;
        return s[31:16];
    endfunction

endpackage

`default_nettype wire

### rtl/core/ncbm_core.sv
// ncbm_core: ten-stage datapath of the cubic basemul, advancing on a common enable
// depends on ncbm_pkg
`default_nettype none

module ncbm_core
    import ncbm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire ncbm_in_t  in_word,
    output ncbm_out_t      out_word
);

    // stage 1: nine operand products, side data carried along
    logic signed [31:0] p_a2b1_reg, p_a1b2_reg, p_a2b2_reg;
    logic signed [31:0] p_a0b0_reg, p_a0b1_reg, p_a1b0_reg;
    logic signed [31:0] p_a2b0_reg, p_a1b1_reg, p_a0b2_reg;
    // stage 2: accumulated sums
    logic signed [31:0] x_t0_reg, x_t1_reg, x_p00_reg, x_s1_reg, x_o2_reg;
    // stage 3: montgomery factors for t0, t1, o2
    logic signed [31:0] y_t0_reg, y_t1_reg, y_p00_reg, y_s1_reg, y_o2_reg;
    logic signed [15:0] u_t0_reg, u_t1_reg, u_o2a_reg;
    // stage 4: reduced t0, t1, o2
    logic signed [15:0] t0_reg, t1_reg, o2a_reg;
    logic signed [31:0] z_p00_reg, z_s1_reg;
    // stage 5: twiddle products folded in
    logic signed [31:0] x_o0_reg, x_o1_reg;
    logic signed [15:0] o2b_reg;
    // stage 6: montgomery factors for o0, o1
    logic signed [31:0] y_o0_reg, y_o1_reg;
    logic signed [15:0] u_o0_reg, u_o1_reg, o2c_reg;
    // stage 7: reduced o0, o1
    logic signed [15:0] o0_reg, o1_reg, o2_reg;
    // stage 8: final scaling sums
    logic signed [31:0] acc0_reg, acc1_reg, acc2_reg;
    // stage 9: final montgomery factors
    logic signed [31:0] w0_reg, w1_reg, w2_reg;
    logic signed [15:0] v0_reg, v1_reg, v2_reg;
    // stage 10: output word
    ncbm_out_t          out_reg;

    // side data: cmd and addend ride to stage 7, zeta to stage 4
    logic               cmd_reg   [7];
    logic signed [15:0] c0_reg    [7];
    logic signed [15:0] c1_reg    [7];
    logic signed [15:0] c2_reg    [7];
    logic signed [15:0] zeta_reg  [4];

    // addend terms, zero in plain mode
    logic signed [31:0] add0, add1, add2;

    always_comb begin
        add0 = cmd_reg[6] ? mul16(c0_reg[6], MONT_R) : 32'sd0;
        add1 = cmd_reg[6] ? mul16(c1_reg[6], MONT_R) : 32'sd0;
        add2 = cmd_reg[6] ? mul16(c2_reg[6], MONT_R) : 32'sd0;
    end

    // side data shift line
    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg[0]  <= in_word.cmd;
            c0_reg[0]   <= in_word.c_0;
            c1_reg[0]   <= in_word.c_1;
            c2_reg[0]   <= in_word.c_2;
            zeta_reg[0] <= in_word.zeta;
            for (int i = 1; i < 7; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
                c0_reg[i]  <= c0_reg[i-1];
                c1_reg[i]  <= c1_reg[i-1];
                c2_reg[i]  <= c2_reg[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                zeta_reg[i] <= zeta_reg[i-1];
            end
        end
    end

    // main datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            p_a2b1_reg <= mul16(in_word.a_2, in_word.b_1);
            p_a1b2_reg <= mul16(in_word.a_1, in_word.b_2);
            p_a2b2_reg <= mul16(in_word.a_2, in_word.b_2);
            p_a0b0_reg <= mul16(in_word.a_0, in_word.b_0);
            p_a0b1_reg <= mul16(in_word.a_0, in_word.b_1);
            p_a1b0_reg <= mul16(in_word.a_1, in_word.b_0);
            p_a2b0_reg <= mul16(in_word.a_2, in_word.b_0);
            p_a1b1_reg <= mul16(in_word.a_1, in_word.b_1);
            p_a0b2_reg <= mul16(in_word.a_0, in_word.b_2);
            // stage 2
            x_t0_reg  <= p_a2b1_reg + p_a1b2_reg;
            x_t1_reg  <= p_a2b2_reg;
            x_p00_reg <= p_a0b0_reg;
            x_s1_reg  <= p_a0b1_reg + p_a1b0_reg;
            x_o2_reg  <= p_a2b0_reg + p_a1b1_reg + p_a0b2_reg;
            // stage 3
            y_t0_reg  <= x_t0_reg;
            y_t1_reg  <= x_t1_reg;
            y_p00_reg <= x_p00_reg;
            y_s1_reg  <= x_s1_reg;
            y_o2_reg  <= x_o2_reg;
            u_t0_reg  <= mont_u(x_t0_reg);
            u_t1_reg  <= mont_u(x_t1_reg);
            u_o2a_reg <= mont_u(x_o2_reg);
            // stage 4
            t0_reg    <= mont_hi(y_t0_reg, u_t0_reg);
            t1_reg    <= mont_hi(y_t1_reg, u_t1_reg);
            o2a_reg   <= mont_hi(y_o2_reg, u_o2a_reg);
            z_p00_reg <= y_p00_reg;
            z_s1_reg  <= y_s1_reg;
            // stage 5
            x_o0_reg  <= mul16(t0_reg, zeta_reg[3]) + z_p00_reg;
            x_o1_reg  <= mul16(t1_reg, zeta_reg[3]) + z_s1_reg;
            o2b_reg   <= o2a_reg;
            // stage 6
            y_o0_reg  <= x_o0_reg;
            y_o1_reg  <= x_o1_reg;
            u_o0_reg  <= mont_u(x_o0_reg);
            u_o1_reg  <= mont_u(x_o1_reg);
            o2c_reg   <= o2b_reg;
            // stage 7
            o0_reg    <= mont_hi(y_o0_reg, u_o0_reg);
            o1_reg    <= mont_hi(y_o1_reg, u_o1_reg);
            o2_reg    <= o2c_reg;
            // stage 8
            acc0_reg  <= mul16(o0_reg, MONT_RSQ) + add0;
            acc1_reg  <= mul16(o1_reg, MONT_RSQ) + add1;
            acc2_reg  <= mul16(o2_reg, MONT_RSQ) + add2;
            // stage 9
            w0_reg    <= acc0_reg;
            w1_reg    <= acc1_reg;
            w2_reg    <= acc2_reg;
            v0_reg    <= mont_u(acc0_reg);
            v1_reg    <= mont_u(acc1_reg);
            v2_reg    <= mont_u(acc2_reg);
            // stage 10
            out_reg.out_0 <= mont_hi(w0_reg, v0_reg);
            out_reg.out_1 <= mont_hi(w1_reg, v1_reg);
            out_reg.out_2 <= mont_hi(w2_reg, v2_reg);
        end
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

### rtl/core/ntt_cubic_basemul_montgomery_top.sv
// ntt_cubic_basemul_montgomery_top: streaming degree-3 basecase multiplier mod q = 3457
// depends on ncbm_pkg and ncbm_core
//
// Usage:
//   s_valid/s_ready/s_data carry one input word: operands a and b, the root zeta,
//   the addend c and cmd (0 plain product, 1 product plus c scaled into Montgomery form).
//   m_valid/m_ready/m_data return one word of three reduced coefficients per input.
//   Throughput is one word per cycle while the receiver takes each output word, set by
//   the ten-stage pipeline in ncbm_core, where every stage holds at most one level
//   of 16x16 multipliers and one add of up to three terms.
//   All stages advance together. When the last stage holds a word that the
//   receiver has not taken, the whole pipeline freezes and s_ready drops;
//   nothing is lost or repeated, and empty slots stay where they are.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers keep
//   whatever they hold and are ignored until refilled.
`default_nettype none

module ntt_cubic_basemul_montgomery_top
    import ncbm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ncbm_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output ncbm_out_t      m_data
);

    // depth is fixed by the stages of ncbm_core
    localparam int DEPTH = NCBM_DEPTH;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             en;

    // pipeline moves unless the output word is held
    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    // valid bits travel with the data
    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // arithmetic pipeline
    ncbm_core u_core (
        .aclk     (aclk),
        .en       (en),
        .in_word  (s_data),
        .out_word (m_data)
    );

endmodule

`default_nettype wire
